// File: rtl/cssnap_pkg.sv
// Package for the cursor snap core: payload words, register map, sequencer states.
// Used by cursor_snap_to_sorted_time_core; depends on nothing.
`default_nettype none
package cssnap_pkg;

  localparam int TABLE_DEPTH_DEF      = 1024;
  localparam int TIME_BITS_DEF        = 48;
  localparam int CURSOR_FRAC_BITS_DEF = 4;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // Register index, taken from paddr[5:3]
  localparam logic [2:0] REG_USABLE_WIDTH = 3'd0;
  localparam logic [2:0] REG_VIEW_START   = 3'd1;
  localparam logic [2:0] REG_VIEW_SPAN    = 3'd2;
  localparam logic [2:0] REG_SLOT_PERIOD  = 3'd3;
  localparam logic [2:0] REG_ENTRY_COUNT  = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic [9:0]         entry_slot;
    logic [47:0]        entry_time_ms;
    logic signed [19:0] cursor_x_q4;
  } in_word_t;

  typedef struct packed {
    logic [48:0] snapped_time_ms;
    logic        has_entry;
    logic [9:0]  entry_position;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL1, S_DIV1, S_TGT, S_KEY, S_LAST, S_NUM, S_DIV2, S_MUL2, S_FAR,
    S_BSR, S_BSC, S_NB, S_NB1, S_NB2, S_NB3, S_PICK, S_DONE
  } st_t;

endpackage
`default_nettype wire

// File: rtl/cssnap_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
`default_nettype none
module cssnap_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/cursor_snap_to_sorted_time_core.sv
// Cursor snap core: sorted time table in cssnap_ram, one shared 65-bit adder
// under a sequencer. Depends on cssnap_pkg and cssnap_ram.
//
// A load word writes one table entry. A query word clamps the cursor, maps it to a
// time with a 64-step shift-add multiply and a 64-step restoring divide, then either
// binary-searches the table (up to log2 of the entry count plus one probes) or, past
// the last entry, rounds to a grid slot with a second 64-step divide and 64-step
// multiply. All of it runs through one adder. A rounded query may land back on the
// last entry. An empty table or zero settings skip the arithmetic, and every query
// may wait for the result register.
// in_ready is low while a query is in work.
`default_nettype none
module cursor_snap_to_sorted_time_core #(
  parameter int TABLE_DEPTH      = cssnap_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS        = cssnap_pkg::TIME_BITS_DEF,
  parameter int CURSOR_FRAC_BITS = cssnap_pkg::CURSOR_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire cssnap_pkg::in_word_t          in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output cssnap_pkg::out_word_t              out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cssnap_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [cssnap_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [cssnap_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                               cfg_pready
);
  import cssnap_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers
  logic [14:0] usable_r;
  logic [47:0] start_r;
  logic [39:0] span_r;
  logic [39:0] period_r;
  logic [10:0] ecount_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= '0;
      start_r  <= '0;
      span_r   <= '0;
      period_r <= '0;
      ecount_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[5:3])
        REG_USABLE_WIDTH: usable_r <= cfg_pwdata[14:0];
        REG_VIEW_START:   start_r  <= cfg_pwdata[47:0];
        REG_VIEW_SPAN:    span_r   <= cfg_pwdata[39:0];
        REG_SLOT_PERIOD:  period_r <= cfg_pwdata[39:0];
        REG_ENTRY_COUNT:  ecount_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_paddr[5:3])
      REG_USABLE_WIDTH: cfg_prdata = 64'(usable_r);
      REG_VIEW_START:   cfg_prdata = 64'(start_r);
      REG_VIEW_SPAN:    cfg_prdata = 64'(span_r);
      REG_SLOT_PERIOD:  cfg_prdata = 64'(period_r);
      REG_ENTRY_COUNT:  cfg_prdata = 64'(ecount_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Clamp entry count to the table depth
  logic [CW-1:0] count;
  assign count = (32'(ecount_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ecount_r);

  // Cursor clamp to [0, usable width in sub-pixels]
  logic [31:0] x_ext, spanpx, xc;
  assign x_ext  = {{12{in_data.cursor_x_q4[19]}}, in_data.cursor_x_q4};
  assign spanpx = 32'(usable_r) << CURSOR_FRAC_BITS;
  assign xc     = x_ext[31] ? 32'd0 : ((x_ext > spanpx) ? spanpx : x_ext);

  // Table memory
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [TIME_BITS-1:0] ram_rdata;
  logic [63:0]          rd64;

  cssnap_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (TIME_BITS'(in_data.entry_time_ms)),
    .rdata (ram_rdata)
  );
  assign rd64 = 64'(ram_rdata);

  // Sequencer and datapath registers
  st_t           state_r, state_nxt;
  logic [63:0]   acc_r, acc_nxt, opa_r, opa_nxt, opb_r, opb_nxt;
  logic [63:0]   key_r, key_nxt, last_r, last_nxt, hit_r, hit_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  out_word_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_data_r, out_data_nxt;

  // Shared adder
  logic [64:0] alu_a, alu_b, alu_y;
  logic        alu_sub;
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  logic          accept;
  logic          degen;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign degen    = (usable_r == '0) || (span_r == '0) || (period_r == '0);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign ram_we   = accept && (in_data.action == ACT_LOAD)
                    && (32'(in_data.entry_slot) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    hit_r      <= hit_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    pick_r     <= pick_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Next state, shared adder operands and datapath updates
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pick_nxt      = pick_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    ram_addr      = AW'(in_data.entry_slot);

    case (state_r)
      S_IDLE: begin
        if (accept && in_data.action == ACT_QUERY) begin
          if (count == '0) begin
            res_nxt   = '{snapped_time_ms: 49'(start_r), has_entry: 1'b0,
                          entry_position: 10'd0};
            state_nxt = S_DONE;
          end else if (degen) begin
            pick_nxt  = '0;
            ram_addr  = '0;
            state_nxt = S_PICK;
          end else begin
            acc_nxt   = '0;
            opa_nxt   = 64'(span_r);
            opb_nxt   = 64'(xc);
            cnt_nxt   = '0;
            state_nxt = S_MUL1;
          end
        end
      end

      // Shift-add multiply step
      S_MUL1, S_MUL2: begin
        alu_a   = {1'b0, acc_r};
        alu_b   = {1'b0, opa_r};
        acc_nxt = opb_r[0] ? alu_y[63:0] : acc_r;
        opa_nxt = opa_r << 1;
        opb_nxt = opb_r >> 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          if (state_r == S_MUL1) begin
            opb_nxt   = acc_nxt;
            acc_nxt   = '0;
            opa_nxt   = 64'(spanpx);
            state_nxt = S_DIV1;
          end else begin
            state_nxt = S_FAR;
          end
        end
      end

      // Restoring divide step: quotient shifts into opb, remainder in acc
      S_DIV1, S_DIV2: begin
        alu_a   = {acc_r, opb_r[63]};
        alu_b   = {1'b0, opa_r};
        alu_sub = 1'b1;
        acc_nxt = alu_y[64] ? alu_a[63:0] : alu_y[63:0];
        opb_nxt = {opb_r[62:0], !alu_y[64]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          if (state_r == S_DIV1) begin
            state_nxt = S_TGT;
          end else if (opb_nxt == '0) begin
            res_nxt   = '{snapped_time_ms: last_r[48:0], has_entry: 1'b1,
                          entry_position: 10'(32'(pick_r))};
            state_nxt = S_DONE;
          end else begin
            acc_nxt   = '0;
            opa_nxt   = 64'(period_r);
            state_nxt = S_MUL2;
          end
        end
      end

      S_TGT: begin
        alu_a     = {17'd0, start_r};
        alu_b     = {1'b0, opb_r};
        acc_nxt   = alu_y[63:0];
        state_nxt = S_KEY;
      end

      // Key = target - half period; fetch the last entry
      S_KEY: begin
        alu_a     = {1'b0, acc_r};
        alu_b     = 65'(period_r >> 1);
        alu_sub   = 1'b1;
        key_nxt   = alu_y[63:0];
        pick_nxt  = AW'(count - CW'(1));
        ram_addr  = pick_nxt;
        state_nxt = S_LAST;
      end

      S_LAST: begin
        alu_a    = {key_r[63], key_r};
        alu_b    = {1'b0, rd64};
        alu_sub  = 1'b1;
        last_nxt = rd64;
        if (!alu_y[64] && alu_y != '0) begin
          acc_nxt   = alu_y[63:0];
          state_nxt = S_NUM;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = count;
          state_nxt = S_BSR;
        end
      end

      // Dividend 2*delta + period, divisor 2*period
      S_NUM: begin
        alu_a     = {acc_r, 1'b0};
        alu_b     = 65'(period_r);
        opb_nxt   = alu_y[63:0];
        acc_nxt   = '0;
        opa_nxt   = {23'd0, period_r, 1'b0};
        cnt_nxt   = '0;
        state_nxt = S_DIV2;
      end

      S_FAR: begin
        alu_a     = {1'b0, last_r};
        alu_b     = {1'b0, acc_r};
        res_nxt   = '{snapped_time_ms: alu_y[48:0], has_entry: 1'b0,
                      entry_position: 10'd0};
        state_nxt = S_DONE;
      end

      // Binary search probe: issue read of mid
      S_BSR: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          ram_addr  = AW'(mid);
          state_nxt = S_BSC;
        end else begin
          state_nxt = S_NB;
        end
      end

      S_BSC: begin
        alu_a     = {1'b0, rd64};
        alu_b     = {key_r[63], key_r};
        alu_sub   = 1'b1;
        if (alu_y[64]) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_BSR;
      end

      S_NB: begin
        if (lo_r == '0 || lo_r >= count) begin
          pick_nxt  = (lo_r == '0) ? '0 : AW'(count - CW'(1));
          ram_addr  = pick_nxt;
          state_nxt = S_PICK;
        end else begin
          ram_addr  = AW'(lo_r);
          state_nxt = S_NB1;
        end
      end

      S_NB1: begin
        hit_nxt   = rd64;
        ram_addr  = AW'(lo_r - CW'(1));
        state_nxt = S_NB2;
      end

      // Distance up from key to the lower bound
      S_NB2: begin
        last_nxt  = rd64;
        alu_a     = {1'b0, hit_r};
        alu_b     = {1'b0, key_r};
        alu_sub   = 1'b1;
        acc_nxt   = alu_y[63:0];
        state_nxt = S_NB3;
      end

      // Distance down; ties go to the predecessor
      S_NB3: begin
        alu_a   = {1'b0, key_r};
        alu_b   = {1'b0, last_r};
        alu_sub = 1'b1;
        if (acc_r < alu_y[63:0]) begin
          res_nxt = '{snapped_time_ms: hit_r[48:0], has_entry: 1'b1,
                      entry_position: 10'(32'(lo_r))};
        end else begin
          res_nxt = '{snapped_time_ms: last_r[48:0], has_entry: 1'b1,
                      entry_position: 10'(32'(lo_r - CW'(1)))};
        end
        state_nxt = S_DONE;
      end

      S_PICK: begin
        res_nxt   = '{snapped_time_ms: rd64[48:0], has_entry: 1'b1,
                      entry_position: 10'(32'(pick_r))};
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_empty_slot_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_entry) |-> (out_data.entry_position == 10'd0))
    else $error("empty slot result carries a position");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV1 || state_r == S_DIV2) && cnt_r != 6'd63) |=> (state_r == $past(state_r)))
    else $error("divide left early");

  a_mul_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MUL1 || state_r == S_MUL2) && cnt_r != 6'd63) |=> (state_r == $past(state_r)))
    else $error("multiply left early");

  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid && state_r == S_IDLE))
    else $error("result not moved to output");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BSC) |-> (lo_r <= hi_r && hi_r <= count))
    else $error("search window out of range");

endmodule
`default_nettype wire
